>>> rtl/htu_pkg.sv
`default_nettype none
package htu_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD      = 3'd0,
    CMD_IDENTITY  = 3'd1,
    CMD_SCALE_ALL = 3'd2,
    CMD_SCALE_AX  = 3'd3,
    CMD_ROTATE    = 3'd4,
    CMD_TRANS_ALL = 3'd5,
    CMD_TRANS_AX  = 3'd6,
    CMD_READ      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,
    S_FOLD,
    S_CORDIC,
    S_FIXUP,
    S_CLEAR,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_ACC,
    S_MAC_SUM,
    S_COPY,
    S_DONE
  } state_t;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] PHASE_PER_RADIAN = 32'd683565276;

  function automatic logic [29:0] arc_at(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0: a = 30'd536870912;
      5'd1: a = 30'd316933406;
      5'd2: a = 30'd167458907;
      5'd3: a = 30'd85004756;
      5'd4: a = 30'd42667331;
      5'd5: a = 30'd21354465;
      5'd6: a = 30'd10679838;
      5'd7: a = 30'd5340245;
      5'd8: a = 30'd2670163;
      5'd9: a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/homogeneous_transform_unit.sv
// Channel   Direction  Signals                                  Transfer
// command   in         start, cmd, axis, value, row, column      start && !busy
// result    out        done, read_value, status                  done (one cycle)
// config    in         psel, penable, pwrite, paddr, pwdata      psel&penable&pwrite
//
// Load, read, identity and range errors go from transfer straight to S_DONE.
// Scale and translate clear, then read, multiply and accumulate R terms and sum,
// for each of the R*C active entries (R, C active dims), then copy the result.
// Rotate first adds S_PHASE, S_FOLD, 30 CORDIC steps and S_FIXUP.
// One shared 32x32 multiplier and accumulator serve the phase and every entry.
// Synchronous reset returns the store to identity at once (flip-flop store).
// The receiver cannot stall; busy stays high until done.
`default_nettype none
module homogeneous_transform_unit
  import htu_pkg::*;
#(
  parameter int MAX_DIM = 4,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         cmd,
  input  wire logic [1:0]         axis,
  input  wire logic signed [31:0] value,
  input  wire logic [1:0]         row,
  input  wire logic [1:0]         column,
  output logic                    done,
  output logic signed [31:0]      read_value,
  output logic [1:0]              status,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int NE = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(NE);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

  logic [2:0] active_rows, active_columns;
  logic [DW-1:0] n, cols;

  logic signed [31:0] mstore [NE];
  logic signed [31:0] fresh [NE];

  state_t state, state_next;
  cmd_t op;
  logic [1:0] ax;
  logic signed [31:0] val;
  logic [IW-1:0] ri, ci, ii;
  logic signed [31:0] coef, elem;
  logic signed [63:0] prod;
  logic signed [63:0] hi_acc, lo_acc;
  logic sat;
  logic [1:0] quad;
  logic signed [33:0] cx, cy, cz;
  logic [4:0] step;
  logic signed [31:0] co, si;
  logic [2:0] ta, tb;

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);

  function automatic logic [AW-1:0] flat_idx(input int r, input int c);
    return AW'(r * MAX_DIM + c);
  endfunction

  always_comb begin
    n = (active_rows == 3'd0) ? DW'(1) :
        (32'(active_rows) > MAX_DIM) ? DW'(MAX_DIM) : DW'(active_rows);
    cols = (active_columns == 3'd0) ? DW'(1) :
           (32'(active_columns) > MAX_DIM) ? DW'(MAX_DIM) : DW'(active_columns);
  end

  always_comb begin
    case (paddr[2])
      1'b0: prdata = {29'd0, active_rows};
      default: prdata = {29'd0, active_columns};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= 3'd4;
      active_columns <= 3'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) active_columns <= pwdata[2:0];
      else active_rows <= pwdata[2:0];
    end
  end

  // transform coefficient for current (ri, ii)
  always_comb begin
    logic [2:0] r3, i3, l3;
    r3 = 3'(ri);
    i3 = 3'(ii);
    l3 = 3'(n - DW'(1));
    coef = (r3 == i3) ? ONE : 32'sd0;
    case (op)
      CMD_SCALE_ALL: if (r3 == i3 && r3 != l3) coef = val;
      CMD_SCALE_AX:  if (r3 == i3 && r3 == {1'b0, ax}) coef = val;
      CMD_TRANS_ALL: if (i3 == l3 && r3 != l3) coef = val;
      CMD_TRANS_AX:  if (i3 == l3 && r3 == {1'b0, ax}) coef = val;
      CMD_ROTATE: begin
        if ((r3 == ta && i3 == ta) || (r3 == tb && i3 == tb)) coef = co;
        else if (r3 == ta && i3 == tb) coef = -si;
        else if (r3 == tb && i3 == ta) coef = si;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ax)
      2'd0: begin ta = 3'd1; tb = 3'd2; end
      2'd1: begin ta = 3'd2; tb = 3'd0; end
      default: begin ta = 3'd0; tb = 3'd1; end
    endcase
  end

  function automatic logic signed [31:0] q30_round(input logic signed [33:0] v);
    logic signed [34:0] t;
    if (FRACTION_BITS >= 30) return 32'(v);
    t = 35'(v) + (35'sd1 <<< (29 - FRACTION_BITS));
    return 32'(t >>> (30 - FRACTION_BITS));
  endfunction

  function automatic logic range_bad(input cmd_t c, input logic [1:0] a,
                                     input logic [DW-1:0] nn);
    logic b;
    b = 1'b0;
    case (c)
      CMD_SCALE_AX, CMD_TRANS_AX:
        b = (a > 2'd2) || (32'(a) + 1 >= 32'(nn));
      CMD_ROTATE:
        b = (a > 2'd2) || (32'(nn) != 3 && 32'(nn) != 4) ||
            (32'(nn) == 3 && a != 2'd2);
      default: b = 1'b0;
    endcase
    return b;
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (start) begin
          if (cmd_t'(cmd) inside {CMD_LOAD, CMD_IDENTITY, CMD_READ} ||
              range_bad(cmd_t'(cmd), axis, n)) state_next = S_DONE;
          else if (cmd_t'(cmd) == CMD_ROTATE) state_next = S_PHASE;
          else state_next = S_CLEAR;
        end
      S_PHASE:  state_next = S_FOLD;
      S_FOLD:   state_next = S_CORDIC;
      S_CORDIC: if (step == 5'(CORDIC_STEPS - 1)) state_next = S_FIXUP;
      S_FIXUP:  state_next = S_CLEAR;
      S_CLEAR:  state_next = S_MAC_RD;
      S_MAC_RD: state_next = S_MAC_MUL;
      S_MAC_MUL: state_next = S_MAC_ACC;
      S_MAC_ACC:
        if (32'(ii) + 1 < 32'(n)) state_next = S_MAC_RD;
        else state_next = S_MAC_SUM;
      S_MAC_SUM:
        if (32'(ci) + 1 < 32'(cols) || 32'(ri) + 1 < 32'(n)) state_next = S_CLEAR;
        else state_next = S_COPY;
      S_COPY: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] h, total;
    logic signed [33:0] sx, sy;
    logic [31:0] phase, rr;
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      for (int k = 0; k < NE; k++)
        mstore[AW'(k)] <= (k / MAX_DIM == k % MAX_DIM) ? ONE : 32'sd0;
    end else begin
      done <= 1'b0;
      state <= state_next;
      case (state)
        S_IDLE: if (start) begin
          op <= cmd_t'(cmd);
          ax <= axis;
          val <= value;
          read_value <= 32'sd0;
          status <= ST_OK;
          sat <= 1'b0;
          ri <= '0;
          ci <= '0;
          case (cmd_t'(cmd))
            CMD_LOAD, CMD_READ:
              if (32'(row) >= 32'(n) || 32'(column) >= 32'(cols)) status <= ST_RANGE;
              else if (cmd_t'(cmd) == CMD_LOAD)
                mstore[flat_idx(int'(row), int'(column))] <= value;
              else read_value <= mstore[flat_idx(int'(row), int'(column))];
            CMD_IDENTITY:
              for (int k = 0; k < NE; k++)
                mstore[AW'(k)] <= (k / MAX_DIM == k % MAX_DIM) ? ONE : 32'sd0;
            default:
              if (range_bad(cmd_t'(cmd), axis, n)) status <= ST_RANGE;
          endcase
        end
        S_PHASE: prod <= 64'(val) * $signed({1'b0, PHASE_PER_RADIAN});
        S_FOLD: begin
          phase = 32'(prod >>> FRACTION_BITS);
          rr = phase - {2'((phase + 32'h2000_0000) >> 30), 30'd0};
          quad <= 2'((phase + 32'h2000_0000) >> 30);
          cz <= 34'($signed(rr));
          cx <= CORDIC_GAIN;
          cy <= 34'sd0;
          step <= 5'd0;
        end
        S_CORDIC: begin
          sx = cx >>> step;
          sy = cy >>> step;
          if (cz >= 0) begin
            cx <= cx - sy;
            cy <= cy + sx;
            cz <= cz - 34'(arc_at(step));
          end else begin
            cx <= cx + sy;
            cy <= cy - sx;
            cz <= cz + 34'(arc_at(step));
          end
          step <= step + 5'd1;
        end
        S_FIXUP: begin
          case (quad)
            2'd0: begin co <= q30_round(cx); si <= q30_round(cy); end
            2'd1: begin co <= q30_round(-cy); si <= q30_round(cx); end
            2'd2: begin co <= q30_round(-cx); si <= q30_round(-cy); end
            default: begin co <= q30_round(cy); si <= q30_round(-cx); end
          endcase
        end
        S_CLEAR: begin
          hi_acc <= '0;
          lo_acc <= '0;
          ii <= '0;
        end
        S_MAC_RD: elem <= mstore[flat_idx(int'(ii), int'(ci))];
        S_MAC_MUL: prod <= 64'(coef) * 64'(elem);
        S_MAC_ACC: begin
          h = prod >>> FRACTION_BITS;
          hi_acc <= hi_acc + h;
          lo_acc <= lo_acc + (prod - (h <<< FRACTION_BITS));
          ii <= ii + IW'(1);
        end
        S_MAC_SUM: begin
          total = hi_acc + ((lo_acc + 64'(ONE >>> 1)) >>> FRACTION_BITS);
          if (total > 64'sd2147483647) begin
            fresh[flat_idx(int'(ri), int'(ci))] <= 32'sh7fff_ffff; sat <= 1'b1;
          end else if (total < -64'sd2147483648) begin
            fresh[flat_idx(int'(ri), int'(ci))] <= 32'sh8000_0000; sat <= 1'b1;
          end else fresh[flat_idx(int'(ri), int'(ci))] <= 32'(total);
          if (32'(ci) + 1 < 32'(cols)) ci <= ci + IW'(1);
          else begin
            ci <= '0;
            ri <= ri + IW'(1);
          end
        end
        S_COPY: begin
          for (int k = 0; k < NE; k++)
            if (k / MAX_DIM < 32'(n) && k % MAX_DIM < 32'(cols))
              mstore[AW'(k)] <= fresh[AW'(k)];
          if (sat) status <= ST_SAT;
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
